@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the wildcard byte pattern scan.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/wbps_pkg.sv @@
// Package with the types and constants of the wildcard byte pattern scan.
package wbps_pkg;

    localparam int LEN_BITS       = 7;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int OFFSET_BITS    = 32;
    localparam int MASK_BITS      = 32;
    localparam int REG_WORDS      = 4;
    localparam int PLEN_BITS      = 6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WILDCARD_MASK  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd5;

    typedef struct packed {
        logic [7:0] pattern_byte;
        logic       wild;
        logic       active;
        logic       tail;
    } cell_cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

@@ rtl/wbps_cell.sv @@
// One cell of the shift-and chain: holds one partial-match bit.
module wbps_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wbps_pkg::cell_ctrl_t ctrl,
    input  wbps_pkg::cell_cfg_t  cfg,
    input  logic [7:0]           data_byte,
    input  logic                 prev_bit,
    output logic                 match_bit,
    output logic                 hit
);
    import wbps_pkg::*;

    logic cand_bit;
    logic bit_reg;
    logic bit_next;

    assign cand_bit = prev_bit & (cfg.wild | (cfg.pattern_byte == data_byte)) & cfg.active;

    always_comb
    begin
        if (ctrl.clear)
        begin
            bit_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            bit_next = cand_bit;
        end
        else
        begin
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign match_bit = bit_reg;
    assign hit       = cand_bit & cfg.tail;

endmodule

@@ rtl/wildcard_byte_pattern_scan.sv @@
// Top level of the wildcard byte pattern scan: configuration, cell chain and result stage.
//
// Usage: software writes the pattern bytes, the wildcard mask and the pattern
// length through the write port (cfg_write_en, cfg_index, cfg_data) while the
// block is idle. The region is then sent one byte per beat on the item channel
// (item_valid, item_stall, data_byte, last_byte); last_byte marks its final byte.
// Each region yields one result beat on the result channel (result_valid,
// result_stall, found, match_offset): found with the start offset at the first
// full match, or not-found with offset zero at the last byte.
// A byte is accepted every cycle while item_stall is low; a row of PATTERN_MAX cells
// updates the partial-match vector per byte, so throughput is one byte per cycle.
// Each result is registered in the result register, or the skid register if that is busy.
// A two-entry output stage (result register and skid register) lets input flow
// on while a result waits; item_stall rises only once both entries are full.
// Reset clears the match state, the byte position and the result stage, and
// sets the pattern registers to zero with a pattern length of one.
`include "assert_macros.svh"

module wildcard_byte_pattern_scan #(
    parameter int PATTERN_MAX   = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                found,
    output logic [wbps_pkg::OFFSET_BITS-1:0]    match_offset
);
    import wbps_pkg::*;

    logic [CFG_DATA_BITS-1:0] pattern_word_reg [REG_WORDS];
    logic [MASK_BITS-1:0]     wildcard_mask_reg;
    logic [PLEN_BITS-1:0]     pattern_length_reg;

    logic [POSITION_BITS-1:0] byte_pos_reg;
    logic [POSITION_BITS-1:0] byte_pos_next;
    logic                     match_seen_reg;
    logic                     match_seen_next;

    logic [LEN_BITS-1:0]      len_eff;
    logic [LEN_BITS-1:0]      len_minus1;
    logic [POSITION_BITS-1:0] start_pos;

    logic                     item_accept;
    logic                     result_take;
    cell_ctrl_t               cell_ctrl;
    logic [PATTERN_MAX:0]     link;
    logic [PATTERN_MAX-1:0]   hit_vec;
    logic                     hit_any;
    logic                     new_valid;
    logic                     new_found;
    logic [OFFSET_BITS-1:0]   new_offset;

    logic                     res_valid_reg;
    logic                     res_found_reg;
    logic [OFFSET_BITS-1:0]   res_offset_reg;
    logic                     skid_valid_reg;
    logic                     skid_found_reg;
    logic [OFFSET_BITS-1:0]   skid_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REG_WORDS; k++)
            begin
                pattern_word_reg[k] <= '0;
            end
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= PLEN_BITS'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_data;
                REG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_data;
                REG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_data;
                REG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_data;
                REG_WILDCARD_MASK:  wildcard_mask_reg   <= cfg_data[MASK_BITS-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg  <= cfg_data[PLEN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (LEN_BITS'(pattern_length_reg) > LEN_BITS'(PATTERN_MAX))
        begin
            len_eff = LEN_BITS'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_BITS'(pattern_length_reg);
        end
    end

    assign len_minus1 = len_eff - LEN_BITS'(1);
    assign start_pos  = byte_pos_reg - POSITION_BITS'(len_minus1);

    assign item_accept     = item_valid & ~item_stall;
    assign result_take     = result_valid & ~result_stall;
    assign cell_ctrl.shift = item_accept & ~match_seen_reg;
    assign cell_ctrl.clear = item_accept & last_byte;

    assign link[0] = 1'b1;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        cell_cfg_t cfg;

        if (j < MASK_BITS)
        begin : g_reg_pos
            assign cfg.pattern_byte = pattern_word_reg[j / 8][(j % 8) * 8 +: 8];
            assign cfg.wild         = wildcard_mask_reg[j];
        end
        else
        begin : g_zero_pos
            assign cfg.pattern_byte = 8'h00;
            assign cfg.wild         = 1'b0;
        end

        assign cfg.active = LEN_BITS'(j) < len_eff;
        assign cfg.tail   = LEN_BITS'(j) == len_minus1;

        wbps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .cfg       (cfg),
            .data_byte (data_byte),
            .prev_bit  (link[j]),
            .match_bit (link[j+1]),
            .hit       (hit_vec[j])
        );
    end

    assign hit_any    = cell_ctrl.shift & (|hit_vec);
    assign new_valid  = item_accept & (hit_any | (last_byte & ~match_seen_reg));
    assign new_found  = hit_any;
    assign new_offset = hit_any ? OFFSET_BITS'(start_pos) : '0;

    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        match_seen_next = match_seen_reg;
        if (item_accept)
        begin
            if (last_byte)
            begin
                byte_pos_next   = '0;
                match_seen_next = 1'b0;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + POSITION_BITS'(1);
                if (hit_any)
                begin
                    match_seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            match_seen_reg <= 1'b0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            match_seen_reg <= match_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (new_valid)
        begin
            if (res_valid_reg && !result_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                res_valid_reg <= 1'b1;
            end
        end
        else if (result_take)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result_take)
            begin
                res_found_reg  <= skid_found_reg;
                res_offset_reg <= skid_offset_reg;
            end
        end
        else if (new_valid)
        begin
            if (res_valid_reg && !result_take)
            begin
                skid_found_reg  <= new_found;
                skid_offset_reg <= new_offset;
            end
            else
            begin
                res_found_reg  <= new_found;
                res_offset_reg <= new_offset;
            end
        end
    end

    assign item_stall   = skid_valid_reg;
    assign result_valid = res_valid_reg;
    assign found        = res_found_reg;
    assign match_offset = res_offset_reg;

    `ASSERT_IMPLIES(a_skid_behind_result, clk, rst_n, skid_valid_reg, res_valid_reg)
    `ASSERT_NEXT(a_region_end_clears, clk, rst_n, item_accept && last_byte,
                 byte_pos_reg == '0 && !match_seen_reg)
    `ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && result_stall, skid_valid_reg)
    `ASSERT_IMPLIES(a_single_hit, clk, rst_n, new_found, !match_seen_reg && item_accept)

endmodule
